>>> src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the downmix and linear resampler block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 2;
    localparam int STEP_W   = 21;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CH_W-1:0]   CH_RESET   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_CHANNEL_COUNT = 1'b0,
        REG_PHASE_STEP    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       last_frame;
    } frame_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       out_last;
    } result_beat_t;

    // Step strobes for the interpolation unit
    typedef struct packed {
        logic load;
        logic mul;
        logic round;
    } lerp_ctrl_t;

endpackage

`default_nettype wire

>>> src/downmix_linear_resampler.sv
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Averages one or two channels into mono and resamples the mono stream by
// linear interpolation at a programmable Q5.16 step.
// ----------------------------------------------------------------------------
// Sequence: a frame beat passes through the mix and difference states, then
//   the shared lerp unit loop (operand load, multiply, round, emit) runs once
//   per result beat; the loop waits in emit while the result side stalls. A
//   lone last frame skips the difference state, and a buffer's first frame
//   only primes the history. Each frame yields 0 to 16 result beats, and a
//   new frame beat is taken only once all results of the last are emitted.
// Reset: rst_n clears the sequencer, history, position and registers to
//   channel_count = 1 and phase_step = 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module downmix_linear_resampler #(
    parameter int MAX_CHANNELS = 2,
    parameter int FRAC_BITS    = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Frame channel
    input  wire                                 frame_valid,
    output logic                                frame_ready,
    input  wire dlr_pkg::frame_beat_t           frame,
    // Result channel
    output logic                                result_valid,
    input  wire                                 result_ready,
    output dlr_pkg::result_beat_t               result,
    // Configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [dlr_pkg::ADDR_W-1:0]           paddr,
    input  wire [dlr_pkg::DATA_W-1:0]           pwdata,
    output logic [dlr_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    // Position is Q(5).FRAC_BITS: it never reaches 17 samples
    localparam int PW = FRAC_BITS + 5;
    localparam int SW = (PW > dlr_pkg::STEP_W) ? PW : dlr_pkg::STEP_W;
    localparam logic [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] TWO     = PW'(2) << FRAC_BITS;
    localparam logic [PW-1:0] POS_LIM = PW'(17) << FRAC_BITS;
    localparam logic [SW-1:0] STEP_LO = SW'(1) << (FRAC_BITS - 3);
    localparam logic [SW-1:0] STEP_HI = SW'(1) << (FRAC_BITS + 4);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MIX   = 7'b0000010,
        ST_DIFF  = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ROUND = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [dlr_pkg::CH_W-1:0]   channel_count_reg;
    logic [dlr_pkg::STEP_W-1:0] phase_step_reg;
    logic                       cfg_write;
    dlr_pkg::reg_index_t        cfg_index;

    // Item and history
    dlr_pkg::frame_beat_t              frame_reg;
    logic signed [dlr_pkg::SAMPLE_W-1:0] mono_reg;
    logic signed [dlr_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [dlr_pkg::SAMPLE_W:0]   diff_reg;
    logic                              have_prev_reg, have_prev_next;
    logic [PW-1:0]                     pos_reg, pos_next;
    logic [PW-1:0]                     step_reg;
    logic                              tail_reg, tail_next;
    logic                              fin_reg, fin_next;

    // Result output register
    logic                  result_valid_reg;
    dlr_pkg::result_beat_t result_reg;

    // Combinational helpers
    logic signed [dlr_pkg::SAMPLE_W:0]   mix_sum;
    logic signed [dlr_pkg::SAMPLE_W-1:0] mono_mix;
    logic                                stereo;
    logic [SW-1:0]                       step_ext;
    logic [PW-1:0]                       step_eff;
    logic                                pos_below_one;
    logic [PW-1:0]                       pos_step;
    logic                                out_free;
    logic                                emit;

    dlr_pkg::lerp_ctrl_t                 lerp_ctrl;
    logic signed [dlr_pkg::SAMPLE_W-1:0] lerp_base;
    logic signed [dlr_pkg::SAMPLE_W:0]   lerp_diff;
    logic [FRAC_BITS-1:0]                lerp_frac;
    logic signed [dlr_pkg::SAMPLE_W-1:0] lerp_result;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait APB, index from the word address
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = dlr_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= dlr_pkg::CH_RESET;
            phase_step_reg    <= dlr_pkg::STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dlr_pkg::REG_CHANNEL_COUNT:
                begin
                    channel_count_reg <= pwdata[dlr_pkg::CH_W-1:0];
                end
                dlr_pkg::REG_PHASE_STEP:
                begin
                    phase_step_reg <= pwdata[dlr_pkg::STEP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            dlr_pkg::REG_CHANNEL_COUNT: prdata = dlr_pkg::DATA_W'(channel_count_reg);
            dlr_pkg::REG_PHASE_STEP:    prdata = dlr_pkg::DATA_W'(phase_step_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Downmix and step clamp
    // ------------------------------------------------------------------
    // Channel count 0 acts as mono; anything above MAX_CHANNELS as MAX_CHANNELS.
    assign stereo  = (MAX_CHANNELS >= 2) && (channel_count_reg >= 2'd2);
    // Average rounded to nearest, ties toward plus infinity
    assign mix_sum = (dlr_pkg::SAMPLE_W+1)'(frame_reg.sample_left)
                   + (dlr_pkg::SAMPLE_W+1)'(frame_reg.sample_right)
                   + (dlr_pkg::SAMPLE_W+1)'(1);
    assign mono_mix = stereo ? mix_sum[dlr_pkg::SAMPLE_W:1] : frame_reg.sample_left;

    always_comb
    begin
        step_ext = SW'(phase_step_reg);
        if (step_ext < STEP_LO)
        begin
            step_ext = STEP_LO;
        end
        else if (step_ext > STEP_HI)
        begin
            step_ext = STEP_HI;
        end
        step_eff = step_ext[PW-1:0];
    end

    assign pos_below_one = (pos_reg < ONE);
    assign pos_step      = pos_reg + step_reg;
    assign out_free      = !result_valid_reg || result_ready;
    assign emit          = (state_reg == ST_EMIT) && out_free;

    // ------------------------------------------------------------------
    // Shared interpolation unit. The tail of a last frame uses it with a
    // zero slope so that every result takes the same path.
    // ------------------------------------------------------------------
    always_comb
    begin
        lerp_ctrl.load  = (state_reg == ST_CHECK) && pos_below_one;
        lerp_ctrl.mul   = (state_reg == ST_MUL);
        lerp_ctrl.round = (state_reg == ST_ROUND);
        lerp_base       = tail_reg ? mono_reg : prev_reg;
        lerp_diff       = tail_reg ? '0 : diff_reg;
        lerp_frac       = tail_reg ? '0 : pos_reg[FRAC_BITS-1:0];
    end

    dlr_lerp_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .ctrl   (lerp_ctrl),
        .base   (lerp_base),
        .diff   (lerp_diff),
        .frac   (lerp_frac),
        .result (lerp_result)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        pos_next       = pos_reg;
        tail_next      = tail_reg;
        fin_next       = fin_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (have_prev_reg)
                begin
                    tail_next  = 1'b0;
                    state_next = ST_DIFF;
                end
                else if (frame_reg.last_frame)
                begin
                    // Lone last frame: hold its sample across [0, 1)
                    tail_next  = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    // First frame of a buffer only primes the history
                    prev_next      = mono_mix;
                    have_prev_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (pos_below_one)
                begin
                    // Flag the final beat of the buffer ahead of time
                    pos_next   = pos_step;
                    fin_next   = tail_reg ? (pos_step >= ONE)
                                          : (frame_reg.last_frame && (pos_step >= TWO));
                    state_next = ST_MUL;
                end
                else if (!tail_reg)
                begin
                    pos_next       = pos_reg - ONE;
                    prev_next      = mono_reg;
                    have_prev_next = 1'b1;
                    if (frame_reg.last_frame)
                    begin
                        tail_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // End of buffer: start the stream over
                    pos_next       = '0;
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign frame_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            tail_reg      <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            pos_reg       <= pos_next;
            tail_reg      <= tail_next;
            fin_reg       <= fin_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            frame_reg <= frame;
        end
        if (state_reg == ST_MIX)
        begin
            mono_reg <= mono_mix;
            step_reg <= step_eff;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= (dlr_pkg::SAMPLE_W+1)'(mono_reg) - (dlr_pkg::SAMPLE_W+1)'(prev_reg);
        end
        if (emit)
        begin
            result_reg.out_sample <= lerp_result;
            result_reg.out_last   <= fin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on emit, drop once the beat is taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A frame beat blocks further frames until its results are worked out
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) |=> !frame_ready)
        else $error("frame accepted twice in a row");

    // Position stays inside [0, 17) samples
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_LIM)
        else $error("output position out of range");

    // With no history, an idle block sits at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !have_prev_reg) |-> (pos_reg == '0))
        else $error("position not cleared at buffer start");

    // An emit never overwrites a beat that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !emit)
        else $error("result beat overwritten");

endmodule

`default_nettype wire

>>> src/dlr_lerp_unit.sv
// ----------------------------------------------------------------------------
// dlr_lerp_unit
// Shared interpolation unit: base + diff * frac, rounded to nearest, in
// three registered steps (load operands, multiply, add and round).
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_lerp_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                         clk,
    input  wire dlr_pkg::lerp_ctrl_t                    ctrl,
    input  wire logic signed [dlr_pkg::SAMPLE_W-1:0]    base,
    input  wire logic signed [dlr_pkg::SAMPLE_W:0]      diff,
    input  wire logic [FRAC_BITS-1:0]                   frac,
    output logic signed [dlr_pkg::SAMPLE_W-1:0]         result
);

    localparam int PROD_W = dlr_pkg::SAMPLE_W + FRAC_BITS + 2;
    localparam int LW     = PROD_W + 1;
    localparam logic signed [LW-1:0] HALF = LW'(1) <<< (FRAC_BITS - 1);

    logic signed [dlr_pkg::SAMPLE_W-1:0] base_reg;
    logic signed [dlr_pkg::SAMPLE_W:0]   diff_reg;
    logic [FRAC_BITS-1:0]                frac_reg;
    logic signed [PROD_W-1:0]            prod_reg;
    logic signed [dlr_pkg::SAMPLE_W-1:0] result_reg;
    logic signed [LW-1:0]                sum;

    always_comb
    begin
        sum = (LW'(base_reg) <<< FRAC_BITS) + LW'(prod_reg) + HALF;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            base_reg <= base;
            diff_reg <= diff;
            frac_reg <= frac;
        end
        if (ctrl.mul)
        begin
            prod_reg <= PROD_W'(diff_reg * $signed({1'b0, frac_reg}));
        end
        if (ctrl.round)
        begin
            result_reg <= sum[FRAC_BITS + dlr_pkg::SAMPLE_W - 1:FRAC_BITS];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
